/* rtl/srtc_pkg.sv */
// Shared types and constants for the serial clock-chip block.
// Used by srtc_time, srtc_core and serial_rtc_pram_interface; no dependencies.
package srtc_pkg;

	localparam int STORE_BYTES_DEF = 32;
	localparam logic [31:0] VALID_HOST_MIN = 32'd1600000000;
	localparam logic [31:0] EPOCH_DELTA = 32'd2082844800;
	localparam int CMD_READ_BIT = 15;
	localparam int CMD_ADDR_HI = 14;
	localparam int CMD_ADDR_LO = 10;
	localparam logic [4:0] BIT_POS_LIMIT = 5'd16;
	localparam logic [3:0] READ_MERGE_POS = 4'd8;
	localparam logic [3:0] WRITE_LAST_POS = 4'd15;
	localparam logic [4:0] TIME_BYTES = 5'd8;
	localparam logic [4:0] TIME_COPY_BYTES = 5'd4;
	localparam logic [4:0] ADDR_COMMIT_LO = 5'd3;
	localparam logic [4:0] ADDR_COMMIT_HI = 5'd7;

	typedef enum logic [1:0] {
		ACT_PIN = 2'd0,
		ACT_TICK = 2'd1,
		ACT_SET_TIME = 2'd2,
		ACT_LOAD = 2'd3
	} action_t;

	typedef struct packed {
		action_t action;
		logic chip_enable;
		logic data_in;
		logic clock_in;
		logic [31:0] host_unix_time;
		logic [31:0] new_machine_time;
		logic [4:0] load_address;
		logic [7:0] load_byte;
	} item_t;

	typedef struct packed {
		logic data_out;
		logic host_time_set;
		logic [31:0] host_time_value;
		logic store_changed;
	} result_t;

endpackage

/* rtl/srtc_time.sv */
// Time conversion between host seconds and machine-epoch seconds.
// Depends on srtc_pkg for the epoch and validity constants.
module srtc_time (
	input logic [31:0] host_time,
	input logic [31:0] commit_time,
	input logic signed [16:0] tz_offset,
	output logic refresh_ok,
	output logic [31:0] machine_time,
	output logic commit_ok,
	output logic [31:0] commit_value
);
	import srtc_pkg::*;

	logic signed [34:0] unix_c;

	assign refresh_ok = host_time >= VALID_HOST_MIN;
	assign machine_time = host_time + EPOCH_DELTA + {{15{tz_offset[16]}}, tz_offset};

	assign unix_c = $signed({3'b000, commit_time}) - $signed({3'b000, EPOCH_DELTA})
		- {{18{tz_offset[16]}}, tz_offset};
	assign commit_ok = unix_c >= $signed({3'b000, VALID_HOST_MIN});
	assign commit_value = unix_c[31:0];

endmodule

/* rtl/srtc_core.sv */
// Serial command decoder, byte store and time handling, one beat per cycle while fire is high.
// Depends on srtc_pkg and srtc_time.
module srtc_core #(
	parameter int STORE_BYTES = srtc_pkg::STORE_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input srtc_pkg::item_t item,
	input logic cfg_we,
	input logic signed [16:0] cfg_wdata,
	output srtc_pkg::result_t res
);
	import srtc_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);

	logic [7:0] st_q [STORE_BYTES];
	logic [7:0] st_n [STORE_BYTES];
	logic last_clk_q, last_clk_n;
	logic [4:0] bp_q, bp_n;
	logic [15:0] cmd_q, cmd_n;
	logic signed [16:0] tz_q;

	logic refresh_ok, commit_ok, commit_req, host_set;
	logic dout_c, changed_c;
	logic [31:0] machine_time, commit_time, commit_value;

	srtc_time u_time (
		.host_time(item.host_unix_time),
		.commit_time(commit_time),
		.tz_offset(tz_q),
		.refresh_ok(refresh_ok),
		.machine_time(machine_time),
		.commit_ok(commit_ok),
		.commit_value(commit_value)
	);

	always_comb begin
		logic [3:0] pos;
		logic [15:0] mask;
		logic [15:0] cmd1;
		logic [4:0] addr;
		logic [7:0] rd;
		st_n = st_q;
		last_clk_n = last_clk_q;
		bp_n = bp_q;
		cmd_n = cmd_q;
		dout_c = 1'b0;
		changed_c = 1'b0;
		commit_req = 1'b0;
		pos = bp_q[3:0];
		mask = 16'h8000 >> pos;
		cmd1 = cmd_q;
		addr = cmd_q[CMD_ADDR_HI:CMD_ADDR_LO];
		rd = '0;
		case (item.action)
			ACT_TICK: begin
				if (refresh_ok) begin
					for (int k = 0; k < 4; k++) begin
						st_n[k] = machine_time[8*k +: 8];
						st_n[k+4] = machine_time[8*k +: 8];
					end
				end
			end
			ACT_SET_TIME: begin
				for (int k = 0; k < 4; k++) begin
					st_n[k] = item.new_machine_time[8*k +: 8];
					st_n[k+4] = item.new_machine_time[8*k +: 8];
				end
				changed_c = 1'b1;
			end
			ACT_LOAD: begin
				st_n[item.load_address[AW-1:0]] = item.load_byte;
			end
			ACT_PIN: begin
				last_clk_n = item.clock_in;
				if (item.chip_enable) begin
					bp_n = '0;
					cmd_n = '0;
				end else if (item.clock_in && !last_clk_q && bp_q < BIT_POS_LIMIT) begin
					if ((pos < READ_MERGE_POS || !cmd_q[CMD_READ_BIT]) && item.data_in)
						cmd1 = cmd_q | mask;
					addr = cmd1[CMD_ADDR_HI:CMD_ADDR_LO];
					if (cmd1[CMD_READ_BIT]) begin
						if (pos == READ_MERGE_POS) begin
							if (addr < TIME_BYTES && refresh_ok) begin
								for (int k = 0; k < 4; k++) begin
									st_n[k] = machine_time[8*k +: 8];
									st_n[k+4] = machine_time[8*k +: 8];
								end
								rd = machine_time[{addr[1:0], 3'b000} +: 8];
							end else begin
								rd = st_q[addr[AW-1:0]];
							end
							cmd1 = cmd1 | {8'h00, rd};
						end
						dout_c = |(cmd1 & mask);
					end else if (pos == WRITE_LAST_POS) begin
						st_n[addr[AW-1:0]] = cmd1[7:0];
						if (addr < TIME_COPY_BYTES) begin
							for (int k = 0; k < 4; k++)
								st_n[k+4] = st_n[k];
							commit_req = addr == ADDR_COMMIT_LO;
						end else if (addr == ADDR_COMMIT_HI) begin
							for (int k = 0; k < 4; k++)
								st_n[k] = st_n[k+4];
							commit_req = 1'b1;
						end
						changed_c = 1'b1;
					end
					cmd_n = cmd1;
					bp_n = bp_q + 5'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// both copies agree after a commit, so the low copy is always a valid source
	assign commit_time = {st_n[3], st_n[2], st_n[1], st_n[0]};

	assign host_set = commit_req && commit_ok;
	assign res = {dout_c, host_set, host_set ? commit_value : 32'd0, changed_c};

	always_ff @(posedge clk) begin
		if (fire)
			st_q <= st_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_clk_q <= 1'b0;
			bp_q <= '0;
			cmd_q <= '0;
		end else if (fire) begin
			last_clk_q <= last_clk_n;
			bp_q <= bp_n;
			cmd_q <= cmd_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tz_q <= '0;
		else if (cfg_we)
			tz_q <= cfg_wdata;
	end

`ifndef SYNTHESIS
	a_bp_limit: assert property (@(posedge clk) disable iff (!arst_n)
		bp_q <= BIT_POS_LIMIT)
		else $error("bit position past limit");
	a_bp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.action != ACT_PIN) |=> $stable(bp_q) && $stable(cmd_q))
		else $error("non-pin beat moved the shifter");
	a_enable_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.action == ACT_PIN && item.chip_enable) |=> bp_q == 5'd0 && cmd_q == 16'd0)
		else $error("enable did not clear shifter");
`endif

endmodule

/* rtl/serial_rtc_pram_interface.sv */
// Serial clock-chip block with a STORE_BYTES parameter store (32 bytes by default).
// Input channel (in_valid/in_ready) carries one beat per pin sample or host
// action: pin sample, tick refresh, set machine time, or store byte load.
// Output channel (out_valid/out_ready) returns exactly one result beat per
// input beat: data_out, host_time_set with host_time_value, store_changed.
// A beat is captured in an input register, processed against the store and
// shifter state, and lands in the result register, which raises out_valid;
// throughput one beat per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops once both are occupied and rises as soon as out_ready
// returns. cfg_we/cfg_wdata write the signed time-zone offset; the user must
// write it only while idle, which the block does not enforce. Reset clears the
// shifter, last clock level, offset and both channel stages; store bytes are
// undefined until loaded or written, with no clearing pass.
// Depends on srtc_pkg and srtc_core.
module serial_rtc_pram_interface #(
	parameter int STORE_BYTES = srtc_pkg::STORE_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] action,
	input logic chip_enable,
	input logic data_in,
	input logic clock_in,
	input logic [31:0] host_unix_time,
	input logic [31:0] new_machine_time,
	input logic [4:0] load_address,
	input logic [7:0] load_byte,
	output logic out_valid,
	input logic out_ready,
	output logic data_out,
	output logic host_time_set,
	output logic [31:0] host_time_value,
	output logic store_changed,
	input logic cfg_we,
	input logic signed [16:0] cfg_wdata
);
	import srtc_pkg::*;

	item_t item_s1;
	logic vld_s1;
	result_t res_c, res_q;
	logic out_vld_q;
	logic advance, fire;

	assign advance = !out_vld_q || out_ready;
	assign fire = vld_s1 && advance;
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action <= action_t'(action);
			item_s1.chip_enable <= chip_enable;
			item_s1.data_in <= data_in;
			item_s1.clock_in <= clock_in;
			item_s1.host_unix_time <= host_unix_time;
			item_s1.new_machine_time <= new_machine_time;
			item_s1.load_address <= load_address;
			item_s1.load_byte <= load_byte;
		end
		if (fire)
			res_q <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_ready)
				vld_s1 <= in_valid;
			if (advance)
				out_vld_q <= vld_s1;
		end
	end

	srtc_core #(
		.STORE_BYTES(STORE_BYTES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item_s1),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.res(res_c)
	);

	assign out_valid = out_vld_q;
	assign data_out = res_q.data_out;
	assign host_time_set = res_q.host_time_set;
	assign host_time_value = res_q.host_time_value;
	assign store_changed = res_q.store_changed;

`ifndef SYNTHESIS
	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("processed beat not presented");
	a_commit_changed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && host_time_set) |-> store_changed)
		else $error("host time commit without store write");
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !host_time_set) |-> host_time_value == 32'd0)
		else $error("host time value without commit");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |-> in_ready)
		else $error("input stalled with empty output");
`endif

endmodule
